FILE: src/banked_mapper_scanline_irq_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros used by the checker of the bank mapper.
// ----------------------------------------------------------------------------
`ifndef BANKED_MAPPER_SCANLINE_IRQ_TOP_ASSERT_SVH
`define BANKED_MAPPER_SCANLINE_IRQ_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define BMSI_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bank mapper assertion failed");

// Next-cycle implication, checked outside reset.
`define BMSI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bank mapper assertion failed");

`endif

FILE: src/bmsi_pkg.sv
// ----------------------------------------------------------------------------
// bmsi_pkg
// Types and constants of the bank mapper with scanline interrupt counter.
// ----------------------------------------------------------------------------
package bmsi_pkg;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_TICK  = 2'd1,
    OP_PRG   = 2'd2,
    OP_CHR   = 2'd3
  } op_e;

  typedef struct packed {
    op_e         opcode;
    logic [15:0] bus_address;
    logic [7:0]  write_data;
  } in_item_t;

  typedef struct packed {
    logic        irq_line;
    logic [18:0] mapped_address;
    logic        mirror_select;
    logic [7:0]  ram_control;
  } out_item_t;

  typedef struct packed {
    logic [5:0] prg_bank_mask;
    logic [7:0] chr_bank_mask;
  } cfg_t;

  // Write decode on address bits 15..13 and bit 0.
  localparam logic [3:0] REG_BANK_SELECT = 4'b1000;
  localparam logic [3:0] REG_BANK_DATA   = 4'b1001;
  localparam logic [3:0] REG_MIRROR      = 4'b1010;
  localparam logic [3:0] REG_RAM_CTRL    = 4'b1011;
  localparam logic [3:0] REG_IRQ_LATCH   = 4'b1100;
  localparam logic [3:0] REG_IRQ_RELOAD  = 4'b1101;
  localparam logic [3:0] REG_IRQ_DISABLE = 4'b1110;
  localparam logic [3:0] REG_IRQ_ENABLE  = 4'b1111;

  // Configuration register indexes.
  localparam logic CFG_PRG_MASK = 1'b0;
  localparam logic CFG_CHR_MASK = 1'b1;

  localparam logic [5:0] PRG_MASK_RESET = 6'h3F;
  localparam logic [7:0] CHR_MASK_RESET = 8'hFF;

  localparam logic [7:0] PRG_BANK_LAST   = 8'hFF;
  localparam logic [7:0] PRG_BANK_SECOND = 8'hFE;

  localparam logic [7:0] BANK_RESET [8] = '{8'd0, 8'd2, 8'd4, 8'd5, 8'd6, 8'd7, 8'd0, 8'd1};

endpackage

FILE: src/bmsi_cfg.sv
// ----------------------------------------------------------------------------
// bmsi_cfg
// APB-style register port holding the program and pattern bank masks.
// ----------------------------------------------------------------------------
module bmsi_cfg
  import bmsi_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg_o
);

  logic [5:0] prg_mask_q, prg_mask_d;
  logic [7:0] chr_mask_q, chr_mask_d;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    prg_mask_d = prg_mask_q;
    chr_mask_d = chr_mask_q;
    if (wr_en) begin
      unique case (paddr[2])
        CFG_PRG_MASK: prg_mask_d = pwdata[5:0];
        CFG_CHR_MASK: chr_mask_d = pwdata[7:0];
        default:      prg_mask_d = prg_mask_q;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      CFG_PRG_MASK: prdata = {26'd0, prg_mask_q};
      CFG_CHR_MASK: prdata = {24'd0, chr_mask_q};
      default:      prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prg_mask_q <= PRG_MASK_RESET;
      chr_mask_q <= CHR_MASK_RESET;
    end else begin
      prg_mask_q <= prg_mask_d;
      chr_mask_q <= chr_mask_d;
    end
  end

  assign cfg_o = '{prg_bank_mask: prg_mask_q, chr_bank_mask: chr_mask_q};

endmodule

FILE: src/bmsi_core.sv
// ----------------------------------------------------------------------------
// bmsi_core
// Mapper state, register write decode, scanline counter and address mapping.
// ----------------------------------------------------------------------------
module bmsi_core
  import bmsi_pkg::*;
#(
  parameter int unsigned PRG_BANK_BITS = 6,
  parameter int unsigned CHR_BANK_BITS = 8
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      fire_i,
  input  in_item_t  item_i,
  input  cfg_t      cfg_i,
  output out_item_t result_o
);

  localparam int unsigned PrgLimit = (1 << PRG_BANK_BITS) - 1;
  localparam int unsigned ChrLimit = (1 << CHR_BANK_BITS) - 1;
  localparam logic [5:0]  PrgLim   = 6'(PrgLimit);
  localparam logic [7:0]  ChrLim   = 8'(ChrLimit);

  logic [7:0] bank_q [8];
  logic [7:0] bank_d [8];
  logic [7:0] sel_q, sel_d;
  logic [7:0] cnt_q, cnt_d;
  logic [7:0] latch_q, latch_d;
  logic       en_q, en_d;
  logic       reload_q, reload_d;
  logic       pend_q, pend_d;
  logic       mirror_q, mirror_d;
  logic [7:0] ram_q, ram_d;

  logic [3:0]  wr_code;
  logic [1:0]  prg_slot;
  logic [7:0]  prg_bank8;
  logic [5:0]  prg_bank;
  logic [2:0]  chr_slot;
  logic [7:0]  chr_raw;
  logic [7:0]  chr_bank;
  logic [18:0] mapped;

  assign wr_code = {item_i.bus_address[15:13], item_i.bus_address[0]};

  always_comb begin
    bank_d   = bank_q;
    sel_d    = sel_q;
    cnt_d    = cnt_q;
    latch_d  = latch_q;
    en_d     = en_q;
    reload_d = reload_q;
    pend_d   = pend_q;
    mirror_d = mirror_q;
    ram_d    = ram_q;
    if (fire_i && item_i.opcode == OP_WRITE) begin
      unique case (wr_code)
        REG_BANK_SELECT: sel_d = item_i.write_data;
        REG_BANK_DATA:   bank_d[sel_q[2:0]] = item_i.write_data;
        REG_MIRROR:      mirror_d = item_i.write_data[0];
        REG_RAM_CTRL:    ram_d = item_i.write_data;
        REG_IRQ_LATCH:   latch_d = item_i.write_data;
        REG_IRQ_RELOAD:  reload_d = 1'b1;
        REG_IRQ_DISABLE: begin
          en_d   = 1'b0;
          pend_d = 1'b0;
        end
        REG_IRQ_ENABLE:  en_d = 1'b1;
        default:         sel_d = sel_q;
      endcase
    end else if (fire_i && item_i.opcode == OP_TICK) begin
      if (cnt_q == 8'd0 || reload_q) begin
        cnt_d    = latch_q;
        reload_d = 1'b0;
      end else begin
        cnt_d = cnt_q - 8'd1;
      end
      if (cnt_q != 8'd0 && cnt_d == 8'd0 && en_q) begin
        pend_d = 1'b1;
      end
    end
  end

  always_comb begin
    prg_slot = item_i.bus_address[14:13];
    if (prg_slot == 2'd1) begin
      prg_bank8 = bank_q[7];
    end else if (prg_slot == 2'd3) begin
      prg_bank8 = PRG_BANK_LAST;
    end else if ((prg_slot == 2'd0) != sel_q[6]) begin
      prg_bank8 = bank_q[6];
    end else begin
      prg_bank8 = PRG_BANK_SECOND;
    end
    prg_bank = prg_bank8[5:0] & cfg_i.prg_bank_mask & PrgLim;

    chr_slot = item_i.bus_address[12:10] ^ {sel_q[7], 2'b00};
    if (!chr_slot[2]) begin
      chr_raw = {bank_q[{2'b00, chr_slot[1]}][7:1], chr_slot[0]};
    end else begin
      chr_raw = bank_q[{1'b0, chr_slot[1:0]} + 3'd2];
    end
    chr_bank = chr_raw & cfg_i.chr_bank_mask & ChrLim;

    case (item_i.opcode)
      OP_PRG:  mapped = {prg_bank, item_i.bus_address[12:0]};
      OP_CHR:  mapped = {1'b0, chr_bank, item_i.bus_address[9:0]};
      default: mapped = 19'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bank_q   <= BANK_RESET;
      sel_q    <= 8'd0;
      cnt_q    <= 8'd0;
      latch_q  <= 8'd0;
      en_q     <= 1'b0;
      reload_q <= 1'b0;
      pend_q   <= 1'b0;
      mirror_q <= 1'b0;
      ram_q    <= 8'd0;
    end else begin
      bank_q   <= bank_d;
      sel_q    <= sel_d;
      cnt_q    <= cnt_d;
      latch_q  <= latch_d;
      en_q     <= en_d;
      reload_q <= reload_d;
      pend_q   <= pend_d;
      mirror_q <= mirror_d;
      ram_q    <= ram_d;
    end
  end

  assign result_o = '{irq_line: pend_d, mapped_address: mapped,
                      mirror_select: mirror_d, ram_control: ram_d};

endmodule

FILE: src/bmsi_skid.sv
// ----------------------------------------------------------------------------
// bmsi_skid
// Result register with a skid stage, so one more input item is taken while the
// receiver holds a result.
// ----------------------------------------------------------------------------
module bmsi_skid
  import bmsi_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  out_item_t data_i,
  output logic      full_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  logic      out_valid_q, out_valid_d;
  logic      skid_valid_q, skid_valid_d;
  out_item_t out_q, out_d;
  out_item_t skid_q, skid_d;
  logic      take;

  assign take = out_valid_q && !out_stall_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (skid_valid_q) begin
      if (take) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (push_i) begin
      if (!out_valid_q || take) begin
        out_d       = data_i;
        out_valid_d = 1'b1;
      end else begin
        skid_d       = data_i;
        skid_valid_d = 1'b1;
      end
    end else if (take) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: src/banked_mapper_scanline_irq_top.sv
// ----------------------------------------------------------------------------
// banked_mapper_scanline_irq_top
// Cartridge bank-switch controller with a scanline interrupt counter.
// ----------------------------------------------------------------------------
// The input channel carries one bus item per cycle: a register write, a
// scanline tick, a program address or a pattern address. It is accepted when
// in_valid_i is high and in_stall_o is low. The write, tick or translation is
// done in the accepting cycle, and its result item (interrupt line, mapped
// address, mirroring bit, RAM-control byte) is registered.
// Throughput is one item per cycle while in_stall_o is low, set by the single
// result register stage.
// When the receiver stalls, the result holds and one further item is taken
// into a skid register; in_stall_o rises only once that register is full.
// Write the bank masks via APB only with no item in flight; not enforced.
// Reset loads the bank registers with 0,2,4,5,6,7,0,1, clears the counter,
// the interrupt controls, mirroring and RAM control, sets both masks to all
// ones and empties the output stages.
// ----------------------------------------------------------------------------
module banked_mapper_scanline_irq_top
  import bmsi_pkg::*;
#(
  parameter int unsigned PRG_BANK_BITS = 6,
  parameter int unsigned CHR_BANK_BITS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_item_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_item_t   out_data_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t      cfg;
  out_item_t result;
  logic      fire;
  logic      full;

  assign in_stall_o = full;
  assign fire       = in_valid_i && !full;

  bmsi_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  bmsi_core #(
    .PRG_BANK_BITS (PRG_BANK_BITS),
    .CHR_BANK_BITS (CHR_BANK_BITS)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .item_i   (in_data_i),
    .cfg_i    (cfg),
    .result_o (result)
  );

  bmsi_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (fire),
    .data_i      (result),
    .full_o      (full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

FILE: src/bmsi_checker.sv
// ----------------------------------------------------------------------------
// bmsi_props
// Port-level checks of the bank mapper, bound to the top level.
// ----------------------------------------------------------------------------
`include "banked_mapper_scanline_irq_top_assert.svh"

module bmsi_props
  import bmsi_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_data_o
);

  logic in_fire;
  logic out_held;

  assign in_fire  = in_valid_i && !in_stall_o;
  assign out_held = out_valid_o && out_stall_i;

  `BMSI_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_held, out_valid_o && $stable(out_data_o))
  `BMSI_ASSERT_IMPLY(a_stall_needs_result, clk_i, rst_ni, in_stall_o, out_valid_o)
  `BMSI_ASSERT_NEXT(a_accept_shows, clk_i, rst_ni, in_fire && !out_stall_i, out_valid_o)
  `BMSI_ASSERT_IMPLY(a_stall_cause, clk_i, rst_ni, $rose(in_stall_o), $past(out_held))

endmodule

bind banked_mapper_scanline_irq_top bmsi_props u_bmsi_props (.*);
